// File: hw/rtl/swdm_pkg.sv
// Shared widths, request codes, status codes and register map for the stack block.
// No dependencies; used by stack_with_delete_middle.
`default_nettype none

package swdm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = 7;
    localparam int DATA_W      = 32;
    localparam int PADDR_W     = 3;

    localparam logic [CNT_W-1:0] CAP_RESET = CNT_W'(20);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STACK_DEPTH);

    localparam logic [1:0] REQ_PUSH    = 2'd0;
    localparam logic [1:0] REQ_POP     = 2'd1;
    localparam logic [1:0] REQ_TOP     = 2'd2;
    localparam logic [1:0] REQ_DEL_MID = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_OVERFLOW  = 2'd1;
    localparam logic [1:0] ST_UNDERFLOW = 2'd2;

    // register select is paddr bit 2
    localparam logic REG_FIXED_MODE = 1'b0;
    localparam logic REG_CAPACITY   = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_SHIFT = 3'b100
    } t_state;

endpackage

`default_nettype wire

// File: hw/rtl/stack_with_delete_middle.sv
// Bounded LIFO stack with push, pop, read top and delete middle requests.
// Depends on swdm_pkg (widths, codes, state type). Storage is one on-chip memory.
//
// Usage:
//   Request channel: drive req_type/push_value with start; a transfer occurs
//   at an edge where start is high and busy is low.
//   Result channel: o_valid is high for exactly one cycle with read value,
//   count, empty flag and status. The receiver cannot stall it.
//   Config: APB write of fixed_mode (addr 0) or stack_capacity (addr 4);
//   pready is always high, reads return the register value.
// Request flow (accept edge to strobe):
//   push and any overflow/underflow: result registered at the accept edge.
//   pop and read top: one memory read, then the result is registered.
//   delete middle: reads the middle word, then reads each word above it and
//   writes it back one place lower as the upper half moves down one place.
// busy is low during the strobe cycle, so a new request can be accepted then;
// push and overflow/underflow leave busy low, so they can be accepted back to back.
// Reset: count cleared, fixed_mode 0, stack_capacity 20; memory is not cleared.
`default_nettype none

module stack_with_delete_middle (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [1:0]                          i_req_type,
    input  wire logic signed [swdm_pkg::DATA_W-1:0]  i_push_value,
    output logic                                     o_valid,
    output logic signed [swdm_pkg::DATA_W-1:0]       o_read_value,
    output logic [swdm_pkg::CNT_W-1:0]               o_item_count,
    output logic                                     o_is_empty,
    output logic [1:0]                               o_status,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [swdm_pkg::PADDR_W-1:0]        paddr,
    input  wire logic [31:0]                         pwdata,
    output logic [31:0]                              prdata,
    output logic                                     pready
);

    logic [swdm_pkg::DATA_W-1:0] mem [swdm_pkg::STACK_DEPTH];

    swdm_pkg::t_state                r_state, n_state;
    logic [swdm_pkg::ADDR_W-1:0]     r_addr, n_addr;
    logic                            r_first, n_first;
    logic                            r_valid, n_valid;
    logic [swdm_pkg::DATA_W-1:0]     r_read_value, n_read_value;
    logic [1:0]                      r_status, n_status;
    logic [swdm_pkg::CNT_W-1:0]      r_count, n_count;
    logic                            r_fixed_mode;
    logic [swdm_pkg::CNT_W-1:0]      r_capacity;
    logic [swdm_pkg::DATA_W-1:0]     r_rdata;

    logic                            accept;
    logic                            cfg_wr;
    logic [swdm_pkg::CNT_W-1:0]      limit;
    logic [swdm_pkg::CNT_W-1:0]      cnt_m1;
    logic [swdm_pkg::CNT_W-1:0]      mid_pos;
    logic [swdm_pkg::ADDR_W-1:0]     rd_addr;
    logic                            w_en;
    logic [swdm_pkg::ADDR_W-1:0]     w_addr;
    logic [swdm_pkg::DATA_W-1:0]     w_data;

    assign busy   = (r_state != swdm_pkg::S_IDLE);
    assign accept = start && !busy;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    assign limit   = (r_fixed_mode && (r_capacity < swdm_pkg::DEPTH_CNT)) ?
                     r_capacity : swdm_pkg::DEPTH_CNT;
    assign cnt_m1  = r_count - swdm_pkg::CNT_W'(1);
    assign mid_pos = cnt_m1 - (r_count >> 1);

    always_comb begin
        if (paddr[2] == swdm_pkg::REG_CAPACITY) begin
            prdata = {{(32-swdm_pkg::CNT_W){1'b0}}, r_capacity};
        end else begin
            prdata = {31'd0, r_fixed_mode};
        end
    end

    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_first      = r_first;
        n_valid      = 1'b0;
        n_read_value = r_read_value;
        n_status     = r_status;
        n_count      = r_count;
        rd_addr      = r_addr;
        w_en         = 1'b0;
        w_addr       = r_addr - swdm_pkg::ADDR_W'(1);
        w_data       = r_rdata;

        case (r_state)
            swdm_pkg::S_IDLE: begin
                if (accept) begin
                    n_read_value = '0;
                    n_status     = swdm_pkg::ST_OK;
                    if (i_req_type == swdm_pkg::REQ_PUSH) begin
                        n_valid = 1'b1;
                        if (r_count >= limit) begin
                            n_status = swdm_pkg::ST_OVERFLOW;
                        end else begin
                            w_en    = 1'b1;
                            w_addr  = r_count[swdm_pkg::ADDR_W-1:0];
                            w_data  = i_push_value;
                            n_count = r_count + swdm_pkg::CNT_W'(1);
                        end
                    end else if (r_count == '0) begin
                        n_valid  = 1'b1;
                        n_status = swdm_pkg::ST_UNDERFLOW;
                    end else begin
                        case (i_req_type)
                            swdm_pkg::REQ_POP: begin
                                rd_addr = cnt_m1[swdm_pkg::ADDR_W-1:0];
                                n_count = cnt_m1;
                                n_state = swdm_pkg::S_READ;
                            end
                            swdm_pkg::REQ_TOP: begin
                                rd_addr = cnt_m1[swdm_pkg::ADDR_W-1:0];
                                n_state = swdm_pkg::S_READ;
                            end
                            swdm_pkg::REQ_DEL_MID: begin
                                rd_addr = mid_pos[swdm_pkg::ADDR_W-1:0];
                                n_addr  = mid_pos[swdm_pkg::ADDR_W-1:0];
                                n_first = 1'b1;
                                n_state = swdm_pkg::S_SHIFT;
                            end
                            default: begin
                                n_state = swdm_pkg::S_IDLE;
                            end
                        endcase
                    end
                end
            end
            swdm_pkg::S_READ: begin
                n_read_value = r_rdata;
                n_valid      = 1'b1;
                n_state      = swdm_pkg::S_IDLE;
            end
            swdm_pkg::S_SHIFT: begin
                // r_rdata holds mem[r_addr]; first word is the removed one
                if (r_first) begin
                    n_read_value = r_rdata;
                    n_first      = 1'b0;
                end else begin
                    w_en = 1'b1;
                end
                if (r_addr == cnt_m1[swdm_pkg::ADDR_W-1:0]) begin
                    n_count = cnt_m1;
                    n_valid = 1'b1;
                    n_state = swdm_pkg::S_IDLE;
                end else begin
                    n_addr  = r_addr + swdm_pkg::ADDR_W'(1);
                    rd_addr = r_addr + swdm_pkg::ADDR_W'(1);
                end
            end
            default: begin
                n_state = swdm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            mem[w_addr] <= w_data;
        end
        r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= swdm_pkg::S_IDLE;
            r_valid      <= 1'b0;
            r_count      <= '0;
            r_fixed_mode <= 1'b0;
            r_capacity   <= swdm_pkg::CAP_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            r_count <= n_count;
            if (cfg_wr) begin
                if (paddr[2] == swdm_pkg::REG_FIXED_MODE) begin
                    r_fixed_mode <= pwdata[0];
                end else begin
                    r_capacity <= pwdata[swdm_pkg::CNT_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr       <= n_addr;
        r_first      <= n_first;
        r_read_value <= n_read_value;
        r_status     <= n_status;
    end

    assign o_valid      = r_valid;
    assign o_read_value = r_read_value;
    assign o_item_count = r_count;
    assign o_is_empty   = (r_count == '0);
    assign o_status     = r_status;

endmodule

`default_nettype wire

// File: dv/tb_stack_with_delete_middle.sv
// Self-checking testbench for stack_with_delete_middle: a directed request table, then
// random request phases under several mode/capacity settings, checked by an in-bench stack.
// Depends on swdm_pkg and the stack_with_delete_middle RTL.
module tb_stack_with_delete_middle;

    typedef struct packed {
        logic signed [swdm_pkg::DATA_W-1:0] read_value;
        logic [swdm_pkg::CNT_W-1:0]         item_count;
        logic                               is_empty;
        logic [1:0]                         status;
    } t_stack_result;

    typedef struct {
        logic [1:0]                  req;
        logic [swdm_pkg::DATA_W-1:0] value;
        bit                          typed;
        t_stack_result               result;
    } t_directed_row;

    typedef struct {
        bit fixed;
        int cap;        // negative: pick at random
        int items;
        int push_pct;
        bit idle;
        bit hold_off;
    } t_phase;

    logic                               i_clk        = 1'b0;
    logic                               i_rst_n      = 1'b0;
    logic                               start        = 1'b0;
    logic [1:0]                         i_req_type   = swdm_pkg::REQ_PUSH;
    logic signed [swdm_pkg::DATA_W-1:0] i_push_value = '0;
    logic                               psel         = 1'b0;
    logic                               penable      = 1'b0;
    logic                               pwrite       = 1'b0;
    logic [swdm_pkg::PADDR_W-1:0]       paddr        = '0;
    logic [31:0]                        pwdata       = '0;
    logic                               busy;
    logic                               o_valid;
    logic signed [swdm_pkg::DATA_W-1:0] o_read_value;
    logic [swdm_pkg::CNT_W-1:0]         o_item_count;
    logic                               o_is_empty;
    logic [1:0]                         o_status;
    logic [31:0]                        prdata;
    logic                               pready;

    stack_with_delete_middle dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_push_value (i_push_value),
        .o_valid      (o_valid),
        .o_read_value (o_read_value),
        .o_item_count (o_item_count),
        .o_is_empty   (o_is_empty),
        .o_status     (o_status),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // shadow copy of the stack and its registers
    logic signed [swdm_pkg::DATA_W-1:0] shadow_words [swdm_pkg::STACK_DEPTH];
    int unsigned                        shadow_count = 0;
    logic                               shadow_fixed = 1'b0;
    logic [swdm_pkg::CNT_W-1:0]         shadow_cap   = swdm_pkg::CAP_RESET;

    t_stack_result pending_results[$];
    int errors = 0;
    int requests_sent = 0;
    int del_mid_sent = 0;
    int overflows_seen = 0;
    int underflows_seen = 0;
    int settings_used = 0;

    t_directed_row directed_rows [21] = '{
        '{swdm_pkg::REQ_POP, 32'h0000_0000, 1'b1,
          '{32'sh0, 7'd0, 1'b1, swdm_pkg::ST_UNDERFLOW}},
        '{swdm_pkg::REQ_TOP, 32'hFFFF_FFFF, 1'b1,
          '{32'sh0, 7'd0, 1'b1, swdm_pkg::ST_UNDERFLOW}},
        '{swdm_pkg::REQ_DEL_MID, 32'h1234_5678, 1'b1,
          '{32'sh0, 7'd0, 1'b1, swdm_pkg::ST_UNDERFLOW}},
        '{swdm_pkg::REQ_PUSH, 32'h7FFF_FFFF, 1'b1,
          '{32'sh0, 7'd1, 1'b0, swdm_pkg::ST_OK}},
        '{swdm_pkg::REQ_PUSH, 32'h8000_0000, 1'b1,
          '{32'sh0, 7'd2, 1'b0, swdm_pkg::ST_OK}},
        '{swdm_pkg::REQ_TOP, 32'h0000_0000, 1'b1,
          '{32'sh8000_0000, 7'd2, 1'b0, swdm_pkg::ST_OK}},
        '{swdm_pkg::REQ_DEL_MID, 32'h0000_0000, 1'b1,
          '{32'sh7FFF_FFFF, 7'd1, 1'b0, swdm_pkg::ST_OK}},
        '{swdm_pkg::REQ_TOP, 32'h0000_0000, 1'b1,
          '{32'sh8000_0000, 7'd1, 1'b0, swdm_pkg::ST_OK}},
        '{swdm_pkg::REQ_DEL_MID, 32'h0000_0000, 1'b1,
          '{32'sh8000_0000, 7'd0, 1'b1, swdm_pkg::ST_OK}},
        '{swdm_pkg::REQ_PUSH,    32'h0000_0000, 1'b0, '0},
        '{swdm_pkg::REQ_PUSH,    32'hFFFF_FFFF, 1'b0, '0},
        '{swdm_pkg::REQ_PUSH,    32'h0000_0001, 1'b0, '0},
        '{swdm_pkg::REQ_PUSH,    32'h5555_AAAA, 1'b0, '0},
        '{swdm_pkg::REQ_PUSH,    32'hAAAA_5555, 1'b0, '0},
        '{swdm_pkg::REQ_DEL_MID, 32'hFFFF_FFFF, 1'b0, '0},
        '{swdm_pkg::REQ_POP,     32'h7FFF_FFFF, 1'b0, '0},
        '{swdm_pkg::REQ_TOP,     32'h0000_0000, 1'b0, '0},
        '{swdm_pkg::REQ_DEL_MID, 32'h0000_0000, 1'b0, '0},
        '{swdm_pkg::REQ_POP,     32'h0000_0000, 1'b0, '0},
        '{swdm_pkg::REQ_POP,     32'h0000_0000, 1'b0, '0},
        '{swdm_pkg::REQ_POP, 32'h0000_0000, 1'b1,
          '{32'sh0, 7'd0, 1'b1, swdm_pkg::ST_UNDERFLOW}}
    };

    t_phase phases [9] = '{
        '{1'b0,  20, 150, 75, 1'b1, 1'b0},
        '{1'b0,  20,  80, 25, 1'b1, 1'b0},
        '{1'b1,   1,  60, 50, 1'b1, 1'b0},
        '{1'b1,   0,  40, 50, 1'b1, 1'b0},
        '{1'b1, 127, 150, 75, 1'b1, 1'b0},
        '{1'b1,  64,  80, 40, 1'b1, 1'b0},
        '{1'b1,  -1, 100, 55, 1'b1, 1'b0},
        '{1'b0,  -1, 100, 50, 1'b1, 1'b1},
        '{1'b1,  20, 170, 55, 1'b0, 1'b0}
    };

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_stack_result stack_apply(logic [1:0] req,
                                                  logic signed [swdm_pkg::DATA_W-1:0] val);
        t_stack_result r;
        int unsigned n;
        int unsigned limit;
        int unsigned pos;
        int unsigned i;
        n = shadow_count;
        limit = (shadow_fixed && shadow_cap < swdm_pkg::STACK_DEPTH) ?
                shadow_cap : swdm_pkg::STACK_DEPTH;
        r.read_value = '0;
        r.status = swdm_pkg::ST_OK;
        if (req == swdm_pkg::REQ_PUSH) begin
            if (n >= limit) begin
                r.status = swdm_pkg::ST_OVERFLOW;
            end else begin
                shadow_words[n] = val;
                shadow_count = n + 1;
            end
        end else if (n == 0) begin
            r.status = swdm_pkg::ST_UNDERFLOW;
        end else if (req == swdm_pkg::REQ_POP) begin
            r.read_value = shadow_words[n-1];
            shadow_count = n - 1;
        end else if (req == swdm_pkg::REQ_TOP) begin
            r.read_value = shadow_words[n-1];
        end else begin
            // middle sits n/2 below the top; everything above slides down
            pos = (n - 1) - n / 2;
            r.read_value = shadow_words[pos];
            for (i = pos; i + 1 < n; i++)
                shadow_words[i] = shadow_words[i+1];
            shadow_count = n - 1;
        end
        r.item_count = swdm_pkg::CNT_W'(shadow_count);
        r.is_empty = (shadow_count == 0);
        return r;
    endfunction

    task automatic send_request(logic [1:0] req, logic [swdm_pkg::DATA_W-1:0] val,
                                bit typed, t_stack_result typed_result);
        t_stack_result predicted;
        start <= 1'b1;
        i_req_type <= req;
        i_push_value <= val;
        do @(posedge i_clk); while (busy);
        predicted = stack_apply(req, val);
        pending_results.push_back(typed ? typed_result : predicted);
        requests_sent++;
        if (req == swdm_pkg::REQ_DEL_MID)
            del_mid_sent++;
        if (predicted.status == swdm_pkg::ST_OVERFLOW)
            overflows_seen++;
        if (predicted.status == swdm_pkg::ST_UNDERFLOW)
            underflows_seen++;
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // write, then read back over the same port
    task automatic write_reg(logic reg_sel, logic [31:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_sel, 2'b00};
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (reg_sel == swdm_pkg::REG_CAPACITY)
            shadow_cap = data[swdm_pkg::CNT_W-1:0];
        else
            shadow_fixed = data[0];
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (reg_sel == swdm_pkg::REG_CAPACITY &&
            prdata[swdm_pkg::CNT_W-1:0] !== data[swdm_pkg::CNT_W-1:0]) begin
            $error("stack_capacity: expected %0d, got %0d", data[swdm_pkg::CNT_W-1:0],
                   prdata[swdm_pkg::CNT_W-1:0]);
            errors++;
        end
        if (reg_sel == swdm_pkg::REG_FIXED_MODE && prdata[0] !== data[0]) begin
            $error("fixed_mode: expected %0d, got %0d", data[0], prdata[0]);
            errors++;
        end
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : result_check
        t_stack_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing expected");
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (o_read_value !== want.read_value) begin
                    $error("read_value: expected %0d, got %0d", want.read_value,
                           o_read_value);
                    errors++;
                end
                if (o_item_count !== want.item_count) begin
                    $error("item_count: expected %0d, got %0d", want.item_count,
                           o_item_count);
                    errors++;
                end
                if (o_is_empty !== want.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", want.is_empty, o_is_empty);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    initial begin
        #10_000_000;
        $display("[stack_with_delete_middle] ERROR");
        $finish;
    end

    initial begin
        logic [1:0]                  req;
        logic [swdm_pkg::DATA_W-1:0] val;
        int                          cap;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[k])
            send_request(directed_rows[k].req, directed_rows[k].value,
                         directed_rows[k].typed, directed_rows[k].result);

        foreach (phases[p]) begin
            wait_drained();
            cap = (phases[p].cap < 0) ? $urandom_range(127) : phases[p].cap;
            write_reg(swdm_pkg::REG_FIXED_MODE, {31'd0, phases[p].fixed});
            write_reg(swdm_pkg::REG_CAPACITY, 32'(cap));
            settings_used++;
            @(posedge i_clk);
            for (int j = 0; j < phases[p].items; j++) begin
                if ($urandom_range(99) < phases[p].push_pct) begin
                    req = swdm_pkg::REQ_PUSH;
                end else begin
                    case ($urandom_range(2))
                        0:       req = swdm_pkg::REQ_POP;
                        1:       req = swdm_pkg::REQ_TOP;
                        default: req = swdm_pkg::REQ_DEL_MID;
                    endcase
                end
                val = $urandom();
                send_request(req, val, 1'b0, '0);
                if (phases[p].hold_off && j == phases[p].items / 2) begin
                    wait_drained();
                end else if (phases[p].idle && $urandom_range(7) == 0) begin
                    start <= 1'b0;
                    repeat ($urandom_range(15, 1)) @(posedge i_clk);
                end
            end
        end

        wait_drained();
        repeat (40) @(posedge i_clk);
        $display("Sent %0d requests (%0d delete-middle) under %0d register settings;",
                 requests_sent, del_mid_sent, settings_used);
        $display("  %0d of them hit overflow and %0d underflow.", overflows_seen,
                 underflows_seen);
        if (errors == 0) begin
            $display("[stack_with_delete_middle] OK");
        end else begin
            $display("[stack_with_delete_middle] ERROR");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/swdm_pkg.sv
hw/rtl/stack_with_delete_middle.sv
dv/tb_stack_with_delete_middle.sv
